/* hw/rtl/fpcc_pkg.sv */
package fpcc_pkg;

  // Frame layout
  localparam int PAYLOAD_BYTES = 32;
  localparam int CHECK_BYTES   = 4;
  localparam int FRAME_BYTES   = PAYLOAD_BYTES + CHECK_BYTES;
  localparam int POS_W         = $clog2(FRAME_BYTES + 1);
  localparam int WORD_W        = 32;
  localparam int ADDR_W        = 3;

  localparam logic [POS_W-1:0] POS_PAYLOAD_END = POS_W'(PAYLOAD_BYTES);
  localparam logic [POS_W-1:0] POS_FRAME_END   = POS_W'(FRAME_BYTES);

  // CRC-32, MSB first
  localparam logic [WORD_W-1:0] CRC_POLY = 32'h04C1_1DB7;

  // Check mode codes; the unused code falls through to CRC
  typedef enum logic [1:0] {
    MODE_EVEN = 2'd0,
    MODE_ODD  = 2'd1,
    MODE_CRC  = 2'd2
  } check_mode_e;

  // Register indexes (byte address bit 2)
  localparam logic REG_CHECK_MODE   = 1'b0;
  localparam logic REG_RECEIVE_MODE = 1'b1;

  typedef struct packed {
    logic [1:0] check_mode;
    logic       receive_mode;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] byte_pos;
  } stat_t;

  // One byte of the CRC, eight shift/xor steps
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                 input logic [7:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      if (c[WORD_W-1]) begin
        c = {c[WORD_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[WORD_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/fpcc_regs.sv */
module fpcc_regs
  import fpcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [1:0] check_mode_q;
  logic       receive_mode_q;
  logic       wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_mode_q   <= MODE_CRC;
      receive_mode_q <= 1'b0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_CHECK_MODE:   check_mode_q   <= pwdata[1:0];
        REG_RECEIVE_MODE: receive_mode_q <= pwdata[0];
        default:          ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      REG_CHECK_MODE:   prdata = {30'h0, check_mode_q};
      REG_RECEIVE_MODE: prdata = {31'h0, receive_mode_q};
      default:          prdata = 32'h0;
    endcase
  end

  assign cfg_o = '{check_mode: check_mode_q, receive_mode: receive_mode_q};

endmodule

/* hw/rtl/fpcc_core.sv */
module fpcc_core
  import fpcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              start_frame_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] check_word_o,
  output logic              mismatch_o,
  output stat_t             stat_o
);

  // Input register
  logic             in_vld_q;
  logic [7:0]       byte_q;
  logic             start_q;
  logic             advance;

  // Frame state
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [WORD_W-1:0] crc_q, crc_d;
  logic [WORD_W-1:0] par_q, par_d;
  logic [WORD_W-1:0] rcv_q, rcv_d;

  // Result register
  logic              out_vld_q;
  logic [WORD_W-1:0] word_q;
  logic              mis_q;

  logic              emit;
  logic              emit_mis;
  logic [WORD_W-1:0] sel_word;
  logic [POS_W-1:0]  pos_cur;
  logic [WORD_W-1:0] crc_cur, par_cur, rcv_cur;

  // Item moves on unless it ends a frame while the result slot is held
  assign advance    = in_vld_q && (!emit || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q  <= data_byte_i;
      start_q <= start_frame_i;
    end
  end

  // Next frame state and result
  always_comb begin
    pos_cur  = start_q ? '0 : pos_q;
    crc_cur  = start_q ? '0 : crc_q;
    par_cur  = start_q ? '0 : par_q;
    rcv_cur  = start_q ? '0 : rcv_q;
    pos_d    = pos_cur;
    crc_d    = crc_cur;
    par_d    = par_cur;
    rcv_d    = rcv_cur;
    emit     = 1'b0;
    emit_mis = 1'b0;
    if (pos_cur < POS_PAYLOAD_END) begin
      crc_d = crc_byte(crc_cur, byte_q);
      par_d = {par_cur[WORD_W-2:0], ~(^byte_q)};
      pos_d = pos_cur + POS_W'(1);
      emit  = (pos_d == POS_PAYLOAD_END) && !cfg_i.receive_mode;
    end else if (cfg_i.receive_mode && (pos_cur < POS_FRAME_END)) begin
      rcv_d    = {rcv_cur[WORD_W-9:0], byte_q};
      pos_d    = pos_cur + POS_W'(1);
      emit     = (pos_d == POS_FRAME_END);
      emit_mis = 1'b1;
    end
  end

  // Word chosen by check mode
  always_comb begin
    case (cfg_i.check_mode)
      MODE_EVEN: sel_word = par_d;
      MODE_ODD:  sel_word = ~par_d;
      default:   sel_word = crc_d;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '0;
      par_q <= '0;
      rcv_q <= '0;
    end else if (advance) begin
      pos_q <= pos_d;
      crc_q <= crc_d;
      par_q <= par_d;
      rcv_q <= rcv_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      word_q <= sel_word;
      mis_q  <= emit_mis && (rcv_d != sel_word);
    end
  end

  assign out_valid_o  = out_vld_q;
  assign check_word_o = word_q;
  assign mismatch_o   = mis_q;
  assign stat_o       = '{byte_pos: pos_q};

endmodule

/* hw/rtl/frame_parity_crc_checker.sv */
// Channel   Signals                                   Direction
// input     in_valid_i, in_stall_o, data_byte_i,      byte in
//           start_frame_i
// output    out_valid_o, out_stall_i, check_word_o,   check word out
//           mismatch_o
// config    psel, penable, pwrite, paddr, pwdata,     APB registers
//           prdata, pready
//
// One byte per cycle while not stalled: an input register, a byte-wide CRC and
// parity update, then a result register loaded as a frame-ending byte moves on.
// Reset (rst_ni low) clears frame state; check_mode resets to CRC-32.
// An output stall holds the result; the input stalls only while a byte that
// ends a frame waits behind a held result.
module frame_parity_crc_checker
  import fpcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        data_byte_i,
  input  logic              start_frame_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] check_word_o,
  output logic              mismatch_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t  cfg;
  stat_t stat;

  fpcc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  fpcc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .start_frame_i(start_frame_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .check_word_o (check_word_o),
    .mismatch_o   (mismatch_o),
    .stat_o       (stat)
  );

`ifndef ASSERT_OFF
  // Input back pressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output back pressure");

  // Byte position never runs past the check bytes
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.byte_pos <= POS_FRAME_END)
    else $error("byte position out of range");

  // A new result only appears at the end of payload or check bytes
  a_result_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      (stat.byte_pos == POS_PAYLOAD_END) || (stat.byte_pos == POS_FRAME_END))
    else $error("result outside frame end");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import fpcc_pkg::*;

  localparam int TOTAL_ITEMS   = 1850;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;

  // Spare check_mode code, decoded as CRC-32
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic [ADDR_W-1:0] ADDR_CHECK_MODE   = ADDR_W'({REG_CHECK_MODE, 2'b00});
  localparam logic [ADDR_W-1:0] ADDR_RECEIVE_MODE = ADDR_W'({REG_RECEIVE_MODE, 2'b00});

  typedef enum logic [1:0] {PL_FLAT, PL_RAMP, PL_RANDOM} fill_e;
  typedef enum logic [1:0] {TL_GIVEN, TL_GOOD, TL_BAD} tail_e;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              miss;
  } check_t;

  // One frame of stimulus: config, payload shape, check word and trailing noise
  typedef struct packed {
    logic [1:0]        mode;
    logic              rx;
    fill_e             pl;
    logic [7:0]        fill0;
    logic [7:0]        fill;
    int                abort;
    logic              nostart;
    logic              mid_sw;
    logic [1:0]        mode_mid;
    tail_e             tl;
    logic [WORD_W-1:0] tail;
    int                extra;
    logic              known;
    logic [WORD_W-1:0] exp_word;
    logic              exp_miss;
  } frame_row_t;

  // Directed frames; exp_word/exp_miss only where known is set
  frame_row_t dir_rows [22] = '{
    '{MODE_CRC, 1'b0, PL_FLAT, 8'h00, 8'h00, 0, 1'b1, 1'b0, MODE_CRC,
      TL_GIVEN, 32'h0, 0, 1'b1, 32'h0000_0000, 1'b0},
    '{MODE_EVEN, 1'b0, PL_FLAT, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_EVEN,
      TL_GIVEN, 32'h0, 0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{MODE_ODD, 1'b0, PL_FLAT, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_ODD,
      TL_GIVEN, 32'h0, 0, 1'b1, 32'h0000_0000, 1'b0},
    '{MODE_EVEN, 1'b0, PL_FLAT, 8'h00, 8'h01, 0, 1'b0, 1'b0, MODE_EVEN,
      TL_GIVEN, 32'h0, 0, 1'b1, 32'h8000_0000, 1'b0},
    '{MODE_ODD, 1'b0, PL_FLAT, 8'h00, 8'h01, 0, 1'b0, 1'b0, MODE_ODD,
      TL_GIVEN, 32'h0, 0, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{MODE_EVEN, 1'b0, PL_FLAT, 8'hFF, 8'hFF, 0, 1'b0, 1'b0, MODE_EVEN,
      TL_GIVEN, 32'h0, 0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{MODE_ODD, 1'b0, PL_FLAT, 8'h7F, 8'h7F, 0, 1'b0, 1'b0, MODE_ODD,
      TL_GIVEN, 32'h0, 0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{MODE_CRC, 1'b0, PL_RAMP, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_CRC,
      TL_GIVEN, 32'h0, 0, 1'b0, 32'h0, 1'b0},
    '{MODE_CRC, 1'b0, PL_FLAT, 8'hFF, 8'hFF, 0, 1'b0, 1'b0, MODE_CRC,
      TL_GIVEN, 32'h0, 0, 1'b0, 32'h0, 1'b0},
    '{MODE_UNUSED, 1'b0, PL_RAMP, 8'h5A, 8'h00, 0, 1'b0, 1'b0, MODE_UNUSED,
      TL_GIVEN, 32'h0, 0, 1'b0, 32'h0, 1'b0},
    '{MODE_CRC, 1'b1, PL_FLAT, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_CRC,
      TL_GIVEN, 32'h0000_0000, 3, 1'b1, 32'h0000_0000, 1'b0},
    '{MODE_CRC, 1'b1, PL_FLAT, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_CRC,
      TL_GIVEN, 32'hFFFF_FFFF, 0, 1'b1, 32'h0000_0000, 1'b1},
    '{MODE_EVEN, 1'b1, PL_FLAT, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_EVEN,
      TL_GIVEN, 32'hFFFF_FFFF, 0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{MODE_ODD, 1'b1, PL_FLAT, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_ODD,
      TL_GIVEN, 32'h0000_0001, 0, 1'b1, 32'h0000_0000, 1'b1},
    '{MODE_CRC, 1'b1, PL_RANDOM, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_CRC,
      TL_GOOD, 32'h0, 0, 1'b0, 32'h0, 1'b0},
    '{MODE_CRC, 1'b1, PL_RANDOM, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_CRC,
      TL_BAD, 32'h0, 0, 1'b0, 32'h0, 1'b0},
    '{MODE_EVEN, 1'b0, PL_RANDOM, 8'h00, 8'h00, 0, 1'b0, 1'b1, MODE_CRC,
      TL_GIVEN, 32'h0, 0, 1'b0, 32'h0, 1'b0},
    '{MODE_CRC, 1'b1, PL_RANDOM, 8'h00, 8'h00, 0, 1'b0, 1'b1, MODE_ODD,
      TL_GOOD, 32'h0, 0, 1'b0, 32'h0, 1'b0},
    '{MODE_ODD, 1'b0, PL_RANDOM, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_ODD,
      TL_GIVEN, 32'h0, 5, 1'b0, 32'h0, 1'b0},
    '{MODE_CRC, 1'b0, PL_FLAT, 8'h00, 8'h00, 10, 1'b0, 1'b0, MODE_CRC,
      TL_GIVEN, 32'h0, 0, 1'b1, 32'h0000_0000, 1'b0},
    '{MODE_UNUSED, 1'b1, PL_RANDOM, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_UNUSED,
      TL_BAD, 32'h0, 2, 1'b0, 32'h0, 1'b0},
    '{MODE_EVEN, 1'b1, PL_RANDOM, 8'h00, 8'h00, 0, 1'b0, 1'b0, MODE_EVEN,
      TL_GOOD, 32'h0, 2, 1'b0, 32'h0, 1'b0}
  };

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [7:0]        data_byte_i   = 8'h00;
  logic              start_frame_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [WORD_W-1:0] check_word_o;
  logic              mismatch_o;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [ADDR_W-1:0] paddr         = '0;
  logic [31:0]       pwdata        = 32'h0;
  logic [31:0]       prdata;
  logic              pready;

  // Checker state as seen from outside
  logic [1:0]        cfg_mode   = MODE_CRC;
  logic              cfg_rx     = 1'b0;
  logic [POS_W-1:0]  frame_pos  = '0;
  logic [WORD_W-1:0] crc_rem    = '0;
  logic [WORD_W-1:0] parity_acc = '0;
  logic [WORD_W-1:0] rx_word    = '0;

  check_t            pending_checks [$];
  logic              pin_set    = 1'b0;
  check_t            pin_res;
  logic              calm       = 1'b0;
  logic              hold_req   = 1'b0;
  int                fail_count = 0;
  int                items_sent = 0;

  frame_parity_crc_checker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .start_frame_i (start_frame_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .check_word_o  (check_word_o),
    .mismatch_o    (mismatch_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Bit-serial LFSR form of the MSB-first CRC
  function automatic logic [WORD_W-1:0] crc_shift(input logic [WORD_W-1:0] c,
                                                  input logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[WORD_W-1] ^ b[k];
      c  = {c[WORD_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
    end
    return c;
  endfunction

  function automatic logic [WORD_W-1:0] frame_word();
    case (cfg_mode)
      MODE_EVEN: return parity_acc;
      MODE_ODD:  return ~parity_acc;
      default:   return crc_rem;
    endcase
  endfunction

  // Advance the frame state by one accepted byte, queue any result it causes
  task automatic predict_byte(input logic [7:0] b, input logic sf);
    check_t r;
    logic   hit;
    hit = 1'b0;
    r   = '0;
    if (sf) begin
      frame_pos  = '0;
      crc_rem    = '0;
      parity_acc = '0;
      rx_word    = '0;
    end
    if (frame_pos < POS_PAYLOAD_END) begin
      crc_rem    = crc_shift(crc_rem, b);
      parity_acc = {parity_acc[WORD_W-2:0], ~^b};
      frame_pos++;
      if (frame_pos == POS_PAYLOAD_END && !cfg_rx) begin
        hit    = 1'b1;
        r.word = frame_word();
        r.miss = 1'b0;
      end
    end else if (cfg_rx && frame_pos < POS_FRAME_END) begin
      rx_word = {rx_word[WORD_W-9:0], b};
      frame_pos++;
      if (frame_pos == POS_FRAME_END) begin
        hit    = 1'b1;
        r.word = frame_word();
        r.miss = (rx_word != r.word);
      end
    end
    if (hit) begin
      if (pin_set) begin
        r       = pin_res;
        pin_set = 1'b0;
      end
      pending_checks.push_back(r);
    end
  endtask

  // Offer one item, random idle cycles first unless calm; valid stays high after
  task automatic send_byte(input logic [7:0] b, input logic sf);
    if (!calm) begin
      while ($urandom_range(0, 99) < 17) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    start_frame_i <= sf;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_byte(b, sf);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain the block, then write whichever registers change
  task automatic program_checker(input logic [1:0] mode, input logic rx);
    in_valid_i <= 1'b0;
    while (pending_checks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mode != cfg_mode) begin
      reg_write(ADDR_CHECK_MODE, 32'(mode));
      cfg_mode = mode;
    end
    if (rx != cfg_rx) begin
      reg_write(ADDR_RECEIVE_MODE, 32'(rx));
      cfg_rx = rx;
    end
  endtask

  task automatic run_frame(input frame_row_t row);
    logic [7:0]        b;
    logic [WORD_W-1:0] tw;
    if (row.mode != cfg_mode || row.rx != cfg_rx) begin
      program_checker(row.mode, row.rx);
    end
    // aborted partial frame, restarted below
    for (int j = 0; j < row.abort; j++) begin
      send_byte(8'($urandom), j == 0);
      items_sent++;
    end
    pin_set = row.known;
    pin_res = {row.exp_word, row.exp_miss};
    for (int i = 0; i < PAYLOAD_BYTES; i++) begin
      if (row.mid_sw && i == PAYLOAD_BYTES / 2) begin
        program_checker(row.mode_mid, cfg_rx);
      end
      case (row.pl)
        PL_FLAT: b = (i == 0) ? row.fill0 : row.fill;
        PL_RAMP: b = row.fill0 + 8'(i);
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == 0 && !row.nostart);
      items_sent++;
    end
    if (row.rx) begin
      case (row.tl)
        TL_GIVEN: tw = row.tail;
        TL_GOOD:  tw = frame_word();
        default:  tw = frame_word() ^ (32'h1 << $urandom_range(0, 31));
      endcase
      for (int k = CHECK_BYTES - 1; k >= 0; k--) begin
        send_byte(tw[8*k +: 8], 1'b0);
        items_sent++;
      end
    end
    // noise past the end of the frame
    for (int j = 0; j < row.extra; j++) begin
      send_byte(8'($urandom), 1'b0);
      items_sent++;
    end
  endtask

  // Output stall: random, quiet during calm, plus one long hold-off on request
  initial begin : result_stall
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 17);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    check_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_checks.size() == 0) begin
        $error("check_word: no result expected, actual %h mismatch %b",
               check_word_o, mismatch_o);
        fail_count++;
      end else begin
        due = pending_checks.pop_front();
        if (check_word_o !== due.word) begin
          $error("check_word: expected %h, actual %h", due.word, check_word_o);
          fail_count++;
        end
        if (mismatch_o !== due.miss) begin
          $error("mismatch: expected %b, actual %b", due.miss, mismatch_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    frame_row_t row;
    logic [1:0] phase_mode;
    logic       phase_rx;
    int         pick;
    int         f;
    row        = dir_rows[0];
    phase_mode = MODE_CRC;
    phase_rx   = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames
    for (int r = 0; r < 22; r++) begin
      run_frame(dir_rows[r]);
    end

    // Random frames: mostly well formed, some aborted, unstarted or noisy
    for (f = 0; items_sent < TOTAL_ITEMS; f++) begin
      if (f % 4 == 0) begin
        if (f / 4 < 8) begin
          phase_mode = 2'(f / 8);
          phase_rx   = 1'((f / 4) % 2);
        end else begin
          phase_mode = 2'($urandom_range(0, 3));
          phase_rx   = 1'($urandom_range(0, 1));
        end
      end
      calm = (f >= 12 && f < 22);
      if (f == 25) hold_req = 1'b1;
      row.mode     = phase_mode;
      row.rx       = phase_rx;
      pick         = $urandom_range(0, 9);
      row.pl       = (pick == 0) ? PL_FLAT : (pick == 1) ? PL_RAMP : PL_RANDOM;
      row.fill0    = 8'($urandom);
      row.fill     = 8'($urandom);
      row.abort    = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 35) : 0;
      row.nostart  = ($urandom_range(0, 19) == 0);
      row.mid_sw   = ($urandom_range(0, 9) == 0);
      row.mode_mid = 2'($urandom_range(0, 3));
      row.tl       = ($urandom_range(0, 4) < 3) ? TL_GOOD : TL_BAD;
      row.tail     = '0;
      row.extra    = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 6) : 0;
      row.known    = 1'b0;
      row.exp_word = '0;
      row.exp_miss = 1'b0;
      run_frame(row);
    end
    calm = 1'b0;

    in_valid_i <= 1'b0;
    while (pending_checks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/fpcc_pkg.sv
hw/rtl/fpcc_regs.sv
hw/rtl/fpcc_core.sv
hw/rtl/frame_parity_crc_checker.sv
dv/testbench.sv
